FILE: hdl/world_to_screen_projection_defines.svh
// Assertion helpers for the projection block.
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// Clocked assertion, masked while reset is asserted.
`define WTSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

`endif

FILE: hdl/wtsp_pkg.sv
package wtsp_pkg;

    localparam int CLIP_W = 50;   // signed clip value
    localparam int MAG_W  = 49;   // magnitude of a clip value
    localparam int W_W    = 48;   // positive clip w
    localparam int QB     = 33;   // quotient bits produced by the cell row
    localparam int NCOEF  = 8;
    localparam int IDX_W  = 4;

    localparam logic signed [CLIP_W-1:0] W_MIN_CODE = CLIP_W'(6554);

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_PAIR_0 = 4'd0,
        REG_COEF_PAIR_7 = 4'd7
    } wtsp_reg_t;

    typedef struct packed {
        logic            vis;
        logic            neg_x;
        logic            neg_y;
        logic            ovf_x;
        logic            ovf_y;
        logic [W_W-1:0]  w;
        logic [W_W-1:0]  rem_x;
        logic [W_W-1:0]  rem_y;
        logic [QB-1:0]   dq_x;
        logic [QB-1:0]   dq_y;
    } wtsp_div_t;

endpackage

FILE: hdl/wtsp_div_cell.sv
module wtsp_div_cell
    import wtsp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      in_valid,
    input  wtsp_div_t in_data,
    output logic      out_valid,
    output wtsp_div_t out_data
);

    logic      valid_reg;
    wtsp_div_t data_reg;
    wtsp_div_t data_next;
    logic [W_W:0] tx, ty;
    logic gex, gey;

    // One restoring step for each of x and y: shift in the next dividend bit.
    always_comb begin
        tx  = {in_data.rem_x, in_data.dq_x[QB-1]};
        ty  = {in_data.rem_y, in_data.dq_y[QB-1]};
        gex = tx >= {1'b0, in_data.w};
        gey = ty >= {1'b0, in_data.w};
        data_next       = in_data;
        data_next.rem_x = gex ? W_W'(tx - {1'b0, in_data.w}) : W_W'(tx);
        data_next.rem_y = gey ? W_W'(ty - {1'b0, in_data.w}) : W_W'(ty);
        data_next.dq_x  = {in_data.dq_x[QB-2:0], gex};
        data_next.dq_y  = {in_data.dq_y[QB-2:0], gey};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: hdl/wtsp_clip.sv
module wtsp_clip
    import wtsp_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             pos_z,
    input  logic [NCOEF-1:0][63:0]         coef,
    output logic                           out_valid,
    output logic signed [CLIP_W-1:0]       clip_x,
    output logic signed [CLIP_W-1:0]       clip_y,
    output logic signed [CLIP_W-1:0]       clip_w
);

    // rows 0, 1 and 3 of the matrix; lane r uses elements ROW[r], 4+ROW[r], 8+ROW[r], 12+ROW[r]
    localparam int ROW [3] = '{0, 1, 3};

    logic                     mul_valid_reg, sum_valid_reg;
    logic signed [63:0]       prod_reg [3][3];
    logic signed [31:0]       trans_reg [3];
    logic signed [CLIP_W-1:0] sum_reg [3];
    logic signed [31:0]       pos [3];

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else if (en) begin
            mul_valid_reg <= in_valid;
            sum_valid_reg <= mul_valid_reg;
        end
    end

    for (genvar r = 0; r < 3; r++) begin : g_row
        for (genvar c = 0; c < 3; c++) begin : g_col
            localparam int E = c * 4 + ROW[r];
            logic signed [31:0] e;
            assign e = $signed(coef[E/2][(E%2)*32 +: 32]);
            always_ff @(posedge aclk) begin
                if (en) begin
                    prod_reg[r][c] <= pos[c] * e;
                end
            end
        end
        localparam int T = 12 + ROW[r];
        always_ff @(posedge aclk) begin
            if (en) begin
                trans_reg[r] <= $signed(coef[T/2][(T%2)*32 +: 32]);
                // arithmetic shift rounds each product toward minus infinity
                sum_reg[r] <= CLIP_W'(prod_reg[r][0] >>> 16)
                            + CLIP_W'(prod_reg[r][1] >>> 16)
                            + CLIP_W'(prod_reg[r][2] >>> 16)
                            + CLIP_W'(trans_reg[r]);
            end
        end
    end

    assign out_valid = sum_valid_reg;
    assign clip_x    = sum_reg[0];
    assign clip_y    = sum_reg[1];
    assign clip_w    = sum_reg[2];

endmodule

FILE: hdl/world_to_screen_projection.sv
// Projects world points to screen pixels through a 4x4 matrix.
// Input channel s_*: one point (pos_x/y/z, signed Q16.16) per transaction.
// Output channel m_*: one result per point, in order: visible flag and
// screen_x/screen_y in signed Q16.16, saturated, zero when not visible.
// Config: cfg_we writes cfg_wdata to coef_pair register cfg_index (0..7);
// other indexes are ignored. Write only while the pipeline is empty.
// Pipeline from input transaction to valid result: two matrix
// stages, one setup stage, 33 division cells (one quotient bit per cell),
// one scale multiply and one output register.
// Throughput: one point per cycle while no result is held back, set by the
// cell row where every cell passes its partial quotient to the next each cycle.
// Reset clears all coefficients (every point reads as not visible) and
// empties the pipeline. When m_ready is low with a result held, the whole
// pipeline freezes and s_ready drops until the result is taken.
module world_to_screen_projection
    import wtsp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 600
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [63:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_visible,
    output logic signed [31:0] m_screen_x,
    output logic signed [31:0] m_screen_y
);

`include "world_to_screen_projection_defines.svh"

    localparam int HALF_W = SCREEN_WIDTH / 2;
    localparam int HALF_H = SCREEN_HEIGHT / 2;
    localparam logic signed [14:0] SCALE_X = 15'(HALF_W + 1);
    localparam logic signed [14:0] SCALE_Y = 15'(HALF_H - 1);
    localparam logic signed [CLIP_W-1:0] OFF_X = CLIP_W'(HALF_W) <<< 16;
    localparam logic signed [CLIP_W-1:0] OFF_Y = CLIP_W'(HALF_H) <<< 16;
    localparam logic signed [CLIP_W-1:0] SAT_MAX = CLIP_W'(32'sh7fff_ffff);
    localparam logic signed [CLIP_W-1:0] SAT_MIN = -(CLIP_W'(33'sh0_8000_0000));

    logic en;
    logic [NCOEF-1:0][63:0] coef_reg;

    logic clip_valid;
    logic signed [CLIP_W-1:0] clip_x, clip_y, clip_w;

    logic      init_valid_reg;
    wtsp_div_t init_reg, init_next;
    logic [MAG_W-1:0] mag_x, mag_y;

    logic      cv [QB+1];
    wtsp_div_t cd [QB+1];

    logic [QB-1:0] nmag_x, nmag_y;
    logic signed [QB:0] nx, ny;
    logic prod_valid_reg, prod_vis_reg;
    logic signed [QB+15:0] prod_x_reg, prod_y_reg;
    logic signed [CLIP_W-1:0] sx, sy;

    logic out_valid_reg, out_vis_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_x_next, out_y_next;

    // advance everything unless a result is held while m_ready is low
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
        end else if (cfg_we && cfg_index <= REG_COEF_PAIR_7) begin
            coef_reg[cfg_index[2:0]] <= cfg_wdata;
        end
    end

    wtsp_clip u_clip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .pos_x     (s_pos_x),
        .pos_y     (s_pos_y),
        .pos_z     (s_pos_z),
        .coef      (coef_reg),
        .out_valid (clip_valid),
        .clip_x    (clip_x),
        .clip_y    (clip_y),
        .clip_w    (clip_w)
    );

    // Dividend is |clip| << 16; its top bits seed the remainder.
    always_comb begin
        mag_x = clip_x[CLIP_W-1] ? MAG_W'(-clip_x) : MAG_W'(clip_x);
        mag_y = clip_y[CLIP_W-1] ? MAG_W'(-clip_y) : MAG_W'(clip_y);
        init_next.vis   = clip_w >= W_MIN_CODE;
        init_next.neg_x = clip_x[CLIP_W-1];
        init_next.neg_y = clip_y[CLIP_W-1];
        init_next.w     = clip_w[W_W-1:0];
        init_next.ovf_x = W_W'(mag_x[MAG_W-1:17]) >= clip_w[W_W-1:0];
        init_next.ovf_y = W_W'(mag_y[MAG_W-1:17]) >= clip_w[W_W-1:0];
        init_next.rem_x = W_W'(mag_x[MAG_W-1:17]);
        init_next.rem_y = W_W'(mag_y[MAG_W-1:17]);
        init_next.dq_x  = {mag_x[16:0], 16'd0};
        init_next.dq_y  = {mag_y[16:0], 16'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_valid_reg <= 1'b0;
        end else if (en) begin
            init_valid_reg <= clip_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            init_reg <= init_next;
        end
    end

    assign cv[0] = init_valid_reg;
    assign cd[0] = init_reg;

    for (genvar i = 0; i < QB; i++) begin : g_cell
        wtsp_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[i]),
            .in_data   (cd[i]),
            .out_valid (cv[i+1]),
            .out_data  (cd[i+1])
        );
    end

    // A quotient past 2^33 saturates the screen anyway; clamp it to 2^32.
    always_comb begin
        nmag_x = cd[QB].ovf_x ? {1'b1, {(QB-1){1'b0}}} : cd[QB].dq_x;
        nmag_y = cd[QB].ovf_y ? {1'b1, {(QB-1){1'b0}}} : cd[QB].dq_y;
        nx = cd[QB].neg_x ? -$signed({1'b0, nmag_x}) : $signed({1'b0, nmag_x});
        ny = cd[QB].neg_y ? -$signed({1'b0, nmag_y}) : $signed({1'b0, nmag_y});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (en) begin
            prod_valid_reg <= cv[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_vis_reg <= cd[QB].vis;
            prod_x_reg   <= nx * SCALE_X;
            prod_y_reg   <= ny * SCALE_Y;
        end
    end

    always_comb begin
        sx = CLIP_W'(prod_x_reg) + OFF_X;
        sy = OFF_Y - CLIP_W'(prod_y_reg);
        if (!prod_vis_reg) begin
            out_x_next = '0;
        end else if (sx > SAT_MAX) begin
            out_x_next = 32'sh7fff_ffff;
        end else if (sx < SAT_MIN) begin
            out_x_next = 32'sh8000_0000;
        end else begin
            out_x_next = sx[31:0];
        end
        if (!prod_vis_reg) begin
            out_y_next = '0;
        end else if (sy > SAT_MAX) begin
            out_y_next = 32'sh7fff_ffff;
        end else if (sy < SAT_MIN) begin
            out_y_next = 32'sh8000_0000;
        end else begin
            out_y_next = sy[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_vis_reg <= prod_vis_reg;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_visible  = out_vis_reg;
    assign m_screen_x = out_x_reg;
    assign m_screen_y = out_y_reg;

    `WTSP_ASSERT(a_hidden_zero, m_valid && !m_visible |-> m_screen_x == 0 && m_screen_y == 0,
        "hidden point with nonzero coordinates")
    `WTSP_ASSERT(a_stall_freeze, m_valid && !m_ready |=> $stable(cv[QB]) && $stable(prod_valid_reg),
        "pipeline advanced during stall")
    `WTSP_ASSERT(a_out_source, $rose(m_valid) |-> $past(prod_valid_reg),
        "result without a source item")

endmodule
